// ----- src/flp_pkg.sv -----
// Shared types, constants and saturation helpers for the four-pole ladder low-pass core.
// No dependencies; the core and the state memory refer to it by scoped names.
package flp_pkg;

   localparam int STATE_DEPTH = 5;
   localparam int ADDR_W = $clog2(STATE_DEPTH);

   typedef logic [ADDR_W-1:0] addr_type;

   // State memory layout
   localparam addr_type ADDR_XPREV = 3'd0;
   localparam addr_type ADDR_S1 = 3'd1;
   localparam addr_type ADDR_S4 = 3'd4;

   // Register indexes of the control port
   localparam logic [1:0] CSR_POLE_GAIN = 2'd0;
   localparam logic [1:0] CSR_POLE_FEEDBACK = 2'd1;
   localparam logic [1:0] CSR_RESONANCE_GAIN = 2'd2;

   localparam logic [20:0] POLE_GAIN_RST = 21'd0;
   localparam logic signed [21:0] POLE_FEEDBACK_RST = -22'sd1048576;
   localparam logic [22:0] RESONANCE_GAIN_RST = 23'd0;

   // 0.166666 in Q.24
   localparam logic signed [31:0] CLIP_COEF = 32'sd2796191;

   localparam logic signed [15:0] SAMPLE_HI = 16'sd16384;
   localparam logic signed [15:0] SAMPLE_LO = -16'sd16384;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RES_MUL,
      ST_RES_SUB,
      ST_MUL_CUR,
      ST_MUL_PREV,
      ST_MUL_Y,
      ST_STAGE_END,
      ST_CLIP_SQ,
      ST_CLIP_CUBE,
      ST_CLIP_TERM,
      ST_CLIP_END
   } seq_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- src/four_pole_ladder_lowpass_core.sv -----
// Four-pole ladder low-pass top level: sequencer, coefficient registers and datapath.
// Depends on flp_pkg, flp_state_mem and flp_mul.
//
//   channel | ports            | payload
//   --------+------------------+------------------------------------
//   request | req_t*           | sample_in, 16-bit signed Q2.14
//   result  | rsp_t*           | sample_out, 16-bit signed Q2.14
//   control | csr_we/index/... | pole_gain, pole_feedback, resonance_gain
//
// Each request runs through one shared multiplier, one product at a time (resonance,
// three per stage for four stages, three for the clipper), and the state memory is
// read one entry ahead of its use.
// A request is accepted only while the output register is empty or draining, so the
// finished result always finds it free; a new request is taken only in the idle state.
// Synchronous reset clears the state memory's valid bits and presets the coefficients.
module four_pole_ladder_lowpass_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sample_out
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   logic [20:0]        pole_gain_ff;
   logic signed [21:0] pole_feedback_ff;
   logic [22:0]        resonance_gain_ff;

   flp_pkg::seq_state_type state_ff, state_in;
   logic [1:0]         stage_ff, stage_in;

   logic signed [31:0] samp_ff;
   logic signed [31:0] cur_ff;
   logic signed [31:0] prev_ff;
   logic signed [31:0] oldy_ff;
   logic signed [39:0] acc_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_prod;
   logic signed [63:0] prod_sh20, prod_sh24;
   logic signed [39:0] p20, p24;

   flp_pkg::addr_type  mem_raddr, mem_waddr;
   logic               mem_we;
   logic signed [31:0] mem_wdata, mem_rdata;

   logic signed [15:0] smp;
   logic signed [15:0] smp_cl;
   logic signed [31:0] x_val;
   logic signed [31:0] y_val;
   logic signed [31:0] sq_val;
   logic signed [31:0] cube_val;
   logic signed [31:0] clip_val;
   logic signed [31:0] out_shift;
   logic               out_free;
   logic               out_load;
   logic               accept;

   flp_state_mem u_mem (
      .clock (clock),
      .reset (reset),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   flp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pole_gain_ff <= flp_pkg::POLE_GAIN_RST;
         pole_feedback_ff <= flp_pkg::POLE_FEEDBACK_RST;
         resonance_gain_ff <= flp_pkg::RESONANCE_GAIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            flp_pkg::CSR_POLE_GAIN: pole_gain_ff <= csr_wdata[20:0];
            flp_pkg::CSR_POLE_FEEDBACK: pole_feedback_ff <= csr_wdata[21:0];
            flp_pkg::CSR_RESONANCE_GAIN: resonance_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Arithmetic around the shared product
   assign prod_sh20 = mul_prod >>> 20;
   assign prod_sh24 = mul_prod >>> 24;
   assign p20 = prod_sh20[39:0];
   assign p24 = prod_sh24[39:0];

   assign smp = req_tdata;
   always_comb begin
      if (smp > flp_pkg::SAMPLE_HI) begin
         smp_cl = flp_pkg::SAMPLE_HI;
      end else if (smp < flp_pkg::SAMPLE_LO) begin
         smp_cl = flp_pkg::SAMPLE_LO;
      end else begin
         smp_cl = smp;
      end
   end

   assign x_val = flp_pkg::sat32({{8{samp_ff[31]}}, samp_ff} - p20);
   assign y_val = flp_pkg::sat32(acc_ff - p20);
   assign sq_val = flp_pkg::sat32(p24);
   assign cube_val = flp_pkg::sat32(p24);
   assign clip_val = flp_pkg::sat32({{8{cur_ff[31]}}, cur_ff} - p24);
   assign out_shift = clip_val >>> 10;

   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flp_pkg::ST_IDLE;
         stage_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sequencer: next state, multiplier operands and memory accesses
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      req_tready = 1'b0;
      mul_a = cur_ff;
      mul_b = cur_ff;
      mem_raddr = flp_pkg::ADDR_S4;
      mem_we = 1'b0;
      mem_waddr = flp_pkg::ADDR_XPREV;
      mem_wdata = cur_ff;
      out_load = 1'b0;
      unique case (state_ff)
         flp_pkg::ST_IDLE: begin
            // hold off a new request while the previous result is still waiting
            req_tready = out_free;
            mem_raddr = flp_pkg::ADDR_S4;
            if (req_tvalid && out_free) begin
               state_in = flp_pkg::ST_RES_MUL;
            end
         end
         flp_pkg::ST_RES_MUL: begin
            mul_a = mem_rdata;
            mul_b = {9'd0, resonance_gain_ff};
            mem_raddr = flp_pkg::ADDR_XPREV;
            state_in = flp_pkg::ST_RES_SUB;
         end
         flp_pkg::ST_RES_SUB: begin
            mem_raddr = flp_pkg::ADDR_S1;
            stage_in = '0;
            state_in = flp_pkg::ST_MUL_CUR;
         end
         flp_pkg::ST_MUL_CUR: begin
            mul_a = cur_ff;
            mul_b = {11'd0, pole_gain_ff};
            // store the stage-one input once its old value has been read
            if (stage_ff == 2'd0) begin
               mem_we = 1'b1;
               mem_waddr = flp_pkg::ADDR_XPREV;
               mem_wdata = cur_ff;
            end
            state_in = flp_pkg::ST_MUL_PREV;
         end
         flp_pkg::ST_MUL_PREV: begin
            mul_a = prev_ff;
            mul_b = {11'd0, pole_gain_ff};
            state_in = flp_pkg::ST_MUL_Y;
         end
         flp_pkg::ST_MUL_Y: begin
            mul_a = oldy_ff;
            mul_b = {{10{pole_feedback_ff[21]}}, pole_feedback_ff};
            state_in = flp_pkg::ST_STAGE_END;
         end
         flp_pkg::ST_STAGE_END: begin
            if (stage_ff != 2'd3) begin
               mem_we = 1'b1;
               mem_waddr = flp_pkg::ADDR_S1 + flp_pkg::addr_type'(stage_ff);
               mem_wdata = y_val;
               mem_raddr = flp_pkg::ADDR_S1 + flp_pkg::addr_type'(stage_ff) + 3'd1;
               stage_in = stage_ff + 2'd1;
               state_in = flp_pkg::ST_MUL_CUR;
            end else begin
               state_in = flp_pkg::ST_CLIP_SQ;
            end
         end
         flp_pkg::ST_CLIP_SQ: begin
            mul_a = cur_ff;
            mul_b = cur_ff;
            state_in = flp_pkg::ST_CLIP_CUBE;
         end
         flp_pkg::ST_CLIP_CUBE: begin
            mul_a = sq_val;
            mul_b = cur_ff;
            state_in = flp_pkg::ST_CLIP_TERM;
         end
         flp_pkg::ST_CLIP_TERM: begin
            mul_a = cube_val;
            mul_b = flp_pkg::CLIP_COEF;
            state_in = flp_pkg::ST_CLIP_END;
         end
         flp_pkg::ST_CLIP_END: begin
            // output register is free: it was empty or draining at acceptance
            mem_we = 1'b1;
            mem_waddr = flp_pkg::ADDR_S4;
            mem_wdata = clip_val;
            out_load = 1'b1;
            state_in = flp_pkg::ST_IDLE;
         end
         default: begin
            state_in = flp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || out_load;

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff <= {{6{smp_cl[15]}}, smp_cl, 10'd0};
      end
      if (out_load) begin
         rsp_data_ff <= flp_pkg::sat16(out_shift);
      end
      unique case (state_ff)
         flp_pkg::ST_RES_SUB: begin
            cur_ff <= x_val;
            prev_ff <= mem_rdata;
         end
         flp_pkg::ST_MUL_CUR: begin
            oldy_ff <= mem_rdata;
         end
         flp_pkg::ST_MUL_PREV: begin
            acc_ff <= p20;
         end
         flp_pkg::ST_MUL_Y: begin
            acc_ff <= acc_ff + p20;
         end
         flp_pkg::ST_STAGE_END: begin
            // stage output feeds the next stage; its old state is the next prev
            cur_ff <= y_val;
            prev_ff <= oldy_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ----- src/flp_state_mem.sv -----
// Filter state memory: five 32-bit entries, one write port, one registered read port.
// Entries never written since reset read as zero through per-entry valid bits. Uses flp_pkg.
module flp_state_mem (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    we,
   input  flp_pkg::addr_type       waddr,
   input  logic signed [31:0]      wdata,
   input  flp_pkg::addr_type       raddr,
   output logic signed [31:0]      rdata
);

   logic signed [31:0] mem [flp_pkg::STATE_DEPTH];
   logic [flp_pkg::STATE_DEPTH-1:0] valid_ff;
   logic signed [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_ff[raddr]) begin
         rdata_ff <= mem[raddr];
      end else begin
         rdata_ff <= '0;
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/flp_mul.sv -----
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// No dependencies.
module flp_mul (
   input  logic                clock,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output logic signed [63:0]  prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule
